// ===== sv/assert_macros.svh =====
// Assertion helpers used by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check the consequent in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Check the consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== sv/mcfir_pkg.sv =====
`default_nettype none
package mcfir_pkg;

  localparam int SAMPLE_W     = 24;
  localparam int COEF_W       = 24;
  localparam int CHAN_W       = 3;
  localparam int TAPIDX_W     = 10;
  localparam int CFG_W        = 4;
  localparam int CFG_IDX_W    = 1;
  localparam int PROD_W       = SAMPLE_W + COEF_W;
  localparam int ROUND_SHIFT  = 20;
  localparam int MIN_TAP_LOG2 = 5;

  localparam logic [CFG_W-1:0] TAP_LOG2_RESET = 4'd9;
  localparam logic [CFG_W-1:0] ACTIVE_RESET   = 4'd2;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_LOG2 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 1'd1;

  typedef struct packed {
    logic                       command;
    logic [CHAN_W-1:0]          channel;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [TAPIDX_W-1:0]        tap_index;
    logic signed [COEF_W-1:0]   tap_value;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          out_channel;
    logic                       bypassed;
  } res_t;

  typedef struct packed {
    logic clear;
    logic valid;
    logic live;
  } mac_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // Tap count from its log2 register, clamped to the supported range.
  function automatic int unsigned taps_of(logic [CFG_W-1:0] lg, int max_taps);
    int unsigned lg_eff;
    int unsigned t;
    lg_eff = (int'(lg) < MIN_TAP_LOG2) ? MIN_TAP_LOG2 : int'(lg);
    t = 32'd1 << lg_eff;
    if (t > max_taps) t = max_taps;
    return t;
  endfunction

  // Active channel count, clamped to one and to the channel capacity.
  function automatic int unsigned chans_of(logic [CFG_W-1:0] raw, int max_ch);
    int unsigned c;
    c = int'(raw);
    if (c < 1) c = 1;
    if (c > max_ch) c = max_ch;
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mcfir_ram.sv =====
`default_nettype none
module mcfir_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 24
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/mcfir_mac.sv =====
`default_nettype none
module mcfir_mac
  import mcfir_pkg::*;
#(
  parameter int ACC_W = 59
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mac_ctl_t                   ctl,
  input  wire logic signed [COEF_W-1:0]   tap,
  input  wire logic signed [SAMPLE_W-1:0] hist,
  output logic                            busy,
  output logic signed [SAMPLE_W-1:0]      result
);

  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(1 << (ROUND_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-8388608);

  mac_ctl_t                 ctl_d;
  logic                     prod_v;
  logic signed [PROD_W-1:0] mult;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  rsum;
  logic signed [ACC_W-1:0]  rsh;

  assign mult = tap * hist;

  // Align control with the registered memory read, then with the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d  <= '0;
      prod_v <= 1'b0;
    end else begin
      ctl_d  <= ctl;
      prod_v <= ctl_d.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod <= ctl_d.live ? mult : '0;
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign busy = ctl_d.valid | prod_v;

  // Round half up and saturate to the sample range.
  always_comb begin
    rsum = acc + RND;
    rsh  = rsum >>> ROUND_SHIFT;
    if (rsh > SAT_MAX) begin
      result = SAT_MAX[SAMPLE_W-1:0];
    end else if (rsh < SAT_MIN) begin
      result = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      result = rsh[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/multichannel_fir_filter.sv =====
// Filtered sample: the shared MAC visits one tap per cycle in ST_RUN, then ST_DRAIN waits
// for the last product before the output register takes the result. Tap write: no result;
// the block stays idle. Inactive channel: the sample goes through ST_EMIT into the output
// register. Requests stall outside ST_IDLE; output stalls hold ST_DRAIN and ST_EMIT.
// Reset loads tap_count_log2 = 9, active_channels = 2, clears write positions and wrap
// flags at once; history reads as zero until written. Taps are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module multichannel_fir_filter
  import mcfir_pkg::*;
#(
  parameter int MAX_TAPS     = 1024,
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_stall,
  input  wire cmd_t                 cmd,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output res_t                      res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int PW     = $clog2(MAX_TAPS);
  localparam int TW     = $clog2(MAX_TAPS + 1);
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW     = $clog2(MAX_CHANNELS + 1);
  localparam int HDEPTH = MAX_CHANNELS * MAX_TAPS;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  // Sequencer and configuration.
  state_t                     state, state_next;
  logic [TW-1:0]              taps;
  logic [CW-1:0]              chans;

  // Per-channel ring pointers; a wrap flag marks a ring filled once since the last clear.
  logic [PW-1:0]              wpos [MAX_CHANNELS];
  logic                       wrapped [MAX_CHANNELS];

  // Per-request working registers.
  logic [PW-1:0]              k;
  logic [PW-1:0]              rd;
  logic                       live;
  logic                       wrap_ok;
  logic [HAW-1:0]             hbase;
  logic [CHAN_W-1:0]          cur_ch;
  logic signed [SAMPLE_W-1:0] cur_sample;

  logic                       accept;
  logic [CH_W-1:0]            in_idx;
  logic                       active;
  logic [PW-1:0]              pos_raw;
  logic [PW-1:0]              pos_in;
  logic                       last_pos;
  logic [HAW-1:0]             base_in;
  logic                       filt_go;
  logic                       byp_go;
  logic                       tap_go;
  logic                       last_k;
  logic                       out_free;
  logic                       load_filt;
  logic                       load_byp;

  mac_ctl_t                   mac_ctl;
  logic                       mac_busy;
  logic signed [SAMPLE_W-1:0] mac_result;
  logic signed [COEF_W-1:0]   tap_rd;
  logic signed [SAMPLE_W-1:0] hist_rd;

  // Decode the incoming request.
  assign accept   = cmd_valid && !cmd_stall;
  assign in_idx   = CH_W'(cmd.channel);
  assign active   = 8'(cmd.channel) < 8'(chans);
  assign pos_raw  = wpos[in_idx];
  assign pos_in   = (TW'(pos_raw) >= taps) ? '0 : pos_raw;
  assign last_pos = (TW'(pos_in) == taps - TW'(1));
  assign base_in  = HAW'(in_idx) * HAW'(MAX_TAPS);
  assign filt_go  = accept && (cmd.command == CMD_FILTER) && active;
  assign byp_go   = accept && (cmd.command == CMD_FILTER) && !active;
  assign tap_go   = accept && (cmd.command == CMD_TAP) && (int'(cmd.tap_index) < MAX_TAPS);
  assign last_k   = (TW'(k) == taps - TW'(1));
  assign out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, request stall and MAC control.
  always_comb begin
    state_next    = state;
    cmd_stall     = (state != ST_IDLE);
    load_filt     = 1'b0;
    load_byp      = 1'b0;
    mac_ctl.clear = filt_go;
    mac_ctl.valid = (state == ST_RUN);
    mac_ctl.live  = live;
    case (state)
      ST_IDLE: begin
        if (filt_go) begin
          state_next = ST_RUN;
        end else if (byp_go) begin
          state_next = ST_EMIT;
        end
      end
      ST_RUN: begin
        if (last_k) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait for the last product to land in the accumulator.
        if (!mac_busy && out_free) begin
          load_filt  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load_byp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Configuration and ring pointers. Any register write drops all history.
  always_ff @(posedge clk) begin
    if (rst) begin
      taps  <= TW'(taps_of(TAP_LOG2_RESET, MAX_TAPS));
      chans <= CW'(chans_of(ACTIVE_RESET, MAX_CHANNELS));
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wpos[i]    <= '0;
        wrapped[i] <= 1'b0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_LOG2: taps  <= TW'(taps_of(cfg_data, MAX_TAPS));
        REG_ACTIVE:   chans <= CW'(chans_of(cfg_data, MAX_CHANNELS));
        default: ;
      endcase
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        wpos[i]    <= '0;
        wrapped[i] <= 1'b0;
      end
    end else if (filt_go) begin
      wpos[in_idx]    <= last_pos ? '0 : pos_in + PW'(1);
      wrapped[in_idx] <= wrapped[in_idx] | last_pos;
    end
  end

  // Walk the taps: k runs upward, rd walks the ring from newest to oldest.
  always_ff @(posedge clk) begin
    if (filt_go) begin
      cur_ch  <= cmd.channel;
      rd      <= pos_in;
      k       <= '0;
      live    <= 1'b1;
      wrap_ok <= wrapped[in_idx];
      hbase   <= base_in;
    end else if (byp_go) begin
      cur_ch     <= cmd.channel;
      cur_sample <= cmd.sample_in;
    end else if (state == ST_RUN) begin
      k <= k + PW'(1);
      if (rd == '0) begin
        // Older slots hold data only if the ring has wrapped since the last clear.
        rd   <= PW'(taps - TW'(1));
        live <= wrap_ok;
      end else begin
        rd <= rd - PW'(1);
      end
    end
  end

  // Output register: hold while stalled, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_filt || load_byp) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_filt) begin
      res.sample_out  <= mac_result;
      res.out_channel <= cur_ch;
      res.bypassed    <= 1'b0;
    end else if (load_byp) begin
      res.sample_out  <= cur_sample;
      res.out_channel <= cur_ch;
      res.bypassed    <= 1'b1;
    end
  end

  mcfir_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (COEF_W)
  ) u_tap_ram (
    .clk   (clk),
    .we    (tap_go),
    .waddr (PW'(cmd.tap_index)),
    .wdata (cmd.tap_value),
    .raddr (k),
    .rdata (tap_rd)
  );

  mcfir_ram #(
    .DEPTH (HDEPTH),
    .WIDTH (SAMPLE_W)
  ) u_hist_ram (
    .clk   (clk),
    .we    (filt_go),
    .waddr (base_in + HAW'(pos_in)),
    .wdata (cmd.sample_in),
    .raddr (hbase + HAW'(rd)),
    .rdata (hist_rd)
  );

  mcfir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .tap    (tap_rd),
    .hist   (hist_rd),
    .busy   (mac_busy),
    .result (mac_result)
  );

  `ASSERT_IMPLY(a_k_in_range, clk, rst, state == ST_RUN, TW'(k) < taps)
  `ASSERT_IMPLY(a_rd_in_range, clk, rst, state == ST_RUN, TW'(rd) < taps)
  `ASSERT_IMPLY(a_mac_idle, clk, rst, state == ST_IDLE, !mac_busy)
  `ASSERT_NEXT(a_filter_starts, clk, rst, filt_go, state == ST_RUN && k == '0 && live)

endmodule
`default_nettype wire

// ===== tb/fir_check_pkg.sv =====
`timescale 1ns / 1ps
package fir_check_pkg;
  import mcfir_pkg::*;

  localparam int FIR_TAPS  = 1024;
  localparam int FIR_CHANS = 8;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  // Expected filter outputs, built from the requests that the block took.
  class fir_scoreboard;
    bit signed [COEF_W-1:0]   coef [FIR_TAPS];
    bit signed [SAMPLE_W-1:0] ring [FIR_CHANS][FIR_TAPS];
    int unsigned              head [FIR_CHANS];
    logic [CFG_W-1:0]         tap_log2_reg;
    logic [CFG_W-1:0]         chan_reg;
    res_t                     pending_results [$];
    int unsigned              mismatches;

    function new();
      tap_log2_reg = TAP_LOG2_RESET;
      chan_reg     = ACTIVE_RESET;
      mismatches   = 0;
      wipe_history();
    endfunction

    function void wipe_history();
      foreach (ring[c, k]) ring[c][k] = '0;
      foreach (head[c]) head[c] = 0;
    endfunction

    function int unsigned tap_len();
      int unsigned lg;
      lg = (tap_log2_reg < MIN_TAP_LOG2) ? MIN_TAP_LOG2 : tap_log2_reg;
      return ((1 << lg) > FIR_TAPS) ? FIR_TAPS : (1 << lg);
    endfunction

    function int unsigned live_channels();
      if (chan_reg < 1) return 1;
      if (chan_reg > FIR_CHANS) return FIR_CHANS;
      return chan_reg;
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    // Any register write also clears every ring and every head.
    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_TAP_LOG2: tap_log2_reg = val;
        REG_ACTIVE:   chan_reg     = val;
        default: ;
      endcase
      wipe_history();
    endfunction

    // Record a tap write or a pass-through; else store the sample, convolve newest first, round and saturate.
    function void note_request(cmd_t c);
      res_t        r;
      longint      acc;
      longint      q;
      int unsigned n;
      int unsigned p;
      int unsigned rd;
      int unsigned k;
      if (c.command == CMD_TAP) begin
        coef[c.tap_index] = c.tap_value;
        return;
      end
      r.out_channel = c.channel;
      if (c.channel >= live_channels()) begin
        r.sample_out = c.sample_in;
        r.bypassed   = 1'b1;
        pending_results.push_back(r);
        return;
      end
      n = tap_len();
      p = head[c.channel];
      if (p >= n) p = 0;
      ring[c.channel][p] = c.sample_in;
      acc = 0;
      rd  = p;
      for (k = 0; k < n; k++) begin
        acc += longint'(coef[k]) * longint'(ring[c.channel][rd]);
        rd = (rd == 0) ? n - 1 : rd - 1;
      end
      head[c.channel] = (p + 1 == n) ? 0 : p + 1;
      q = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (q > OUT_MAX) q = OUT_MAX;
      if (q < OUT_MIN) q = OUT_MIN;
      r.sample_out = q[SAMPLE_W-1:0];
      r.bypassed   = 1'b0;
      pending_results.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: sample_out %0d out_channel %0d bypassed %0d",
               got.sample_out, got.out_channel, got.bypassed);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.sample_out !== want.sample_out) begin
        $error("sample_out: expected %0d, actual %0d", want.sample_out, got.sample_out);
        mismatches++;
      end
      if (got.out_channel !== want.out_channel) begin
        $error("out_channel: expected %0d, actual %0d", want.out_channel, got.out_channel);
        mismatches++;
      end
      if (got.bypassed !== want.bypassed) begin
        $error("bypassed: expected %0d, actual %0d", want.bypassed, got.bypassed);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import mcfir_pkg::*;
  import fir_check_pkg::*;

  localparam int unsigned RUN_LIMIT = 1000000;  // cycles before the run is called hung
  localparam int          HOLD_SPAN = 600;      // long receiver hold-off, in cycles

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  cmd_t                 cmd = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  fir_scoreboard sb;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          requests_offered = 0;
  int          hold_asks = 0;
  int unsigned cycles = 0;

  multichannel_fir_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hang guard: a correct run ends far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check what was taken at this edge, then pick the next stall.
  // A bump of hold_asks starts one long hold-off so the filter backs up.
  initial begin : receiver
    int hold_left;
    int asks_seen;
    hold_left = 0;
    asks_seen = 0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) sb.check_result(res);
      if (hold_asks != asks_seen) begin
        asks_seen = hold_asks;
        hold_left = HOLD_SPAN;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      res_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sample values weighted toward full scale and zero.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
      1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Random coefficient, shrunk by an arithmetic shift to steer the gain.
  function automatic logic signed [COEF_W-1:0] pick_coef(input int unsigned shift);
    logic signed [COEF_W-1:0] v;
    v = COEF_W'($urandom);
    return v >>> shift;
  endfunction

  function automatic cmd_t sample_req(input int ch, input logic signed [SAMPLE_W-1:0] s);
    cmd_t c;
    c.command   = CMD_FILTER;
    c.channel   = CHAN_W'(ch);
    c.sample_in = s;
    c.tap_index = TAPIDX_W'($urandom);
    c.tap_value = COEF_W'($urandom);
    return c;
  endfunction

  function automatic cmd_t tap_req(input int idx, input logic signed [COEF_W-1:0] v);
    cmd_t c;
    c.command   = CMD_TAP;
    c.channel   = CHAN_W'($urandom);
    c.sample_in = SAMPLE_W'($urandom);
    c.tap_index = TAPIDX_W'(idx);
    c.tap_value = v;
    return c;
  endfunction

  // Mostly samples on any channel; some tap rewrites, half of them on live taps.
  function automatic cmd_t random_req(input int unsigned shift);
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1))
        return tap_req($urandom_range(sb.tap_len() - 1), pick_coef(shift));
      return tap_req($urandom_range(FIR_TAPS - 1), COEF_W'($urandom));
    end
    return sample_req($urandom_range(FIR_CHANS - 1), pick_sample());
  endfunction

  // Offer one request; idle the sender first when the dice say so.
  // Hold the payload until the edge where the block takes it.
  task automatic send_req(input cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    sb.note_request(c);
  endtask

  // Counted request: advance the idling pattern by how far the run has come.
  task automatic offer(input cmd_t c);
    requests_offered++;
    if (requests_offered < 190) begin
      send_idle_pct = 6;
      recv_idle_pct = 81;
    end else if (requests_offered < 380) begin
      send_idle_pct = 81;
      recv_idle_pct = 6;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    send_req(c);
  endtask

  // Drop valid and wait until every result is in.
  task automatic wait_results();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // Quiesce fully: results in, then let a trailing tap write or pass finish.
  task automatic settle();
    wait_results();
    repeat (sb.tap_len() + 8) @(posedge clk);
  endtask

  // Write both registers back to back; only call while the block is idle.
  task automatic configure(input logic [CFG_W-1:0] lg, input logic [CFG_W-1:0] chans);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TAP_LOG2;
    cfg_data  <= lg;
    @(posedge clk);
    sb.note_config(REG_TAP_LOG2, lg);
    cfg_index <= REG_ACTIVE;
    cfg_data  <= chans;
    @(posedge clk);
    sb.note_config(REG_ACTIVE, chans);
    cfg_we <= 1'b0;
  endtask

  // Load every tap in use so no sample ever reads an unwritten coefficient.
  task automatic load_filter(input int unsigned shift);
    for (int k = 0; k < int'(sb.tap_len()); k++) send_req(tap_req(k, pick_coef(shift)));
  endtask

  // One setting: idle, configure, fresh taps, then random traffic.
  // With squeeze set, hold the result side off for a long stretch at the
  // start and pause the sender halfway until the block has drained.
  task automatic run_phase(input logic [CFG_W-1:0] lg, input logic [CFG_W-1:0] chans,
                           input int n, input int unsigned shift, input bit squeeze);
    settle();
    configure(lg, chans);
    load_filter(shift);
    if (squeeze) hold_asks <= hold_asks + 1;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 2) wait_results();
      offer(random_req(shift));
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: 512 taps, two channels. Drive only inactive channels
    // here, since no tap is loaded yet; each passes through flagged.
    offer(sample_req(7, 24'sh800000));
    offer(sample_req(2, 24'sh7FFFFF));
    offer(sample_req(5, 24'sh000000));
    offer(sample_req(3, 24'sh5A5A5A));

    // Tap log2 below the floor acts as 32 taps; make all eight channels active.
    settle();
    configure(4'd3, 4'd8);
    for (int k = 0; k < 32; k++) send_req(tap_req(k, (k == 0) ? 24'sh100000 : 24'sh000000));
    // Unity tap: full scale goes straight through.
    offer(sample_req(0, 24'sh7FFFFF));
    offer(sample_req(0, 24'sh800000));
    // Smallest tap: exercise round-half-up at plus and minus one half LSB.
    offer(tap_req(0, 24'sh000001));
    offer(sample_req(4, 24'sh080000));
    offer(sample_req(4, -24'sh080000));
    offer(sample_req(4, -24'sh080001));
    // Largest tap: drive the sum into both saturation rails.
    offer(tap_req(0, 24'sh7FFFFF));
    offer(sample_req(7, 24'sh7FFFFF));
    offer(sample_req(7, 24'sh800000));
    // Tap above the kernel length: kept but never used.
    offer(tap_req(1023, 24'sh800000));
    offer(tap_req(31, 24'sh7FFFFF));
    offer(sample_req(1, 24'sh7FFFFF));
    offer(sample_req(6, 24'sh000000));

    // Random settings: smallest and largest kernels, channel counts clamped
    // from both ends. Keep the 1024-tap phases short.
    run_phase(4'd5,  4'd1,  90,  9, 1'b0);
    run_phase(4'd6,  4'd15, 100, 11, 1'b0);
    run_phase(4'd10, 4'd8,  14,  13, 1'b0);
    run_phase(4'd7,  4'd0,  90,  8, 1'b0);
    run_phase(4'd15, 4'd3,  8,   12, 1'b0);
    run_phase(4'd8,  4'd5,  90,  10, 1'b0);
    run_phase(4'd5,  4'd8,  160, 6, 1'b1);

    settle();
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
